>>> sv/binary_insertion_index_sort_assert.svh
// assertion macros for the index sort block
`ifndef BINARY_INSERTION_INDEX_SORT_ASSERT_SVH
`define BINARY_INSERTION_INDEX_SORT_ASSERT_SVH
`ifndef SYNTHESIS
`define BIIS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BIIS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BIIS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BIIS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/biis_pkg.sv
// shared types, constants and compare functions for the index sort block
`timescale 1ns / 1ps
package biis_pkg;
   localparam int MaxItems = 64;
   localparam int IdxW = $clog2(MaxItems);
   localparam int CntW = $clog2(MaxItems + 1);
   localparam int KeyW = 64;

   // controller state, one-hot
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_FIRST = 10'b0000000010,
      ST_LAST  = 10'b0000000100,
      ST_EDGE  = 10'b0000001000,
      ST_MIDRD = 10'b0000010000,
      ST_MIDCM = 10'b0000100000,
      ST_SHIFT = 10'b0001000000,
      ST_EMRD  = 10'b0010000000,
      ST_EMIT  = 10'b0100000000,
      ST_EMWT  = 10'b1000000000
   } state_type;

   // controller commands to the datapath
   typedef struct packed {
      logic store_key;   // write key and start a search
      logic rd_first;    // read rank 0
      logic rd_last;     // read rank hi
      logic rd_mid;      // read rank mid
      logic mid_step;    // apply the middle compare
      logic shift_step;  // one shift step of the list
      logic append;      // place index at the end
      logic em_rd;       // read list for emit
      logic em_next;     // advance emit pointer
      logic clear_set;   // end of data set
      logic drop;        // key dropped
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic le_first;    // v <= first
      logic last_le;     // last <= v
      logic span_small;  // span <= 2
      logic mid_eq;      // v neither below nor above mid key
      logic shift_done;
      logic em_last;
   } stat_type;

   // ieee less-than on bit patterns
   function automatic logic fp_lt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
      logic a_nan, b_nan, a_z, b_z, r;
      a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
      b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
      a_z = (a[62:0] == '0);
      b_z = (b[62:0] == '0);
      if (a_nan || b_nan || (a_z && b_z)) r = 1'b0;
      else if (a[63] != b[63]) r = a[63];
      else if (a[63]) r = (a[62:0] > b[62:0]);
      else r = (a[62:0] < b[62:0]);
      return r;
   endfunction

   // ieee equality on bit patterns
   function automatic logic fp_eq(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
      logic a_nan, b_nan;
      a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
      b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
      return !a_nan && !b_nan && ((a == b) || ((a[62:0] == '0) && (b[62:0] == '0)));
   endfunction
endpackage

>>> sv/biis_datapath.sv
// key store, index list, search pointers and compare logic
`timescale 1ns / 1ps
`include "binary_insertion_index_sort_assert.svh"
module biis_datapath import biis_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [KeyW-1:0] key,
   input  cmd_type         cmd,
   output stat_type        stat,
   output logic [IdxW-1:0] sorted_index,
   output logic            overflow
);
   logic [KeyW-1:0] key_mem [MaxItems];
   logic [IdxW-1:0] list_mem [MaxItems];
   logic [CntW-1:0] count_ff, count_in;
   logic            drop_ff, drop_in;
   logic [KeyW-1:0] v_ff;
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in, pos_ff, pos_in, ptr_ff, ptr_in;
   logic [IdxW-1:0] lrd_ff;     // list read data
   logic [KeyW-1:0] krd_ff;     // key read data
   logic [IdxW-1:0] sh_ff;      // entry moving up during shift
   logic [CntW-1:0] mid;
   logic [IdxW-1:0] list_raddr;
   logic            lt_v, gt_v, eq_v, le_rv;

   assign mid = lo_ff + ((hi_ff - lo_ff + CntW'(1)) >> 1);
   assign lt_v  = fp_lt(v_ff, krd_ff);
   assign gt_v  = fp_lt(krd_ff, v_ff);
   assign eq_v  = fp_eq(v_ff, krd_ff);
   assign le_rv = gt_v || eq_v;

   // list read address
   always_comb begin
      list_raddr = ptr_ff[IdxW-1:0];
      if (cmd.rd_first || cmd.em_rd) list_raddr = '0;
      else if (cmd.rd_last) list_raddr = hi_ff[IdxW-1:0];
      else if (cmd.rd_mid) list_raddr = mid[IdxW-1:0];
   end

   // key store and list memories
   always_ff @(posedge clock) begin
      if (cmd.store_key) key_mem[count_ff[IdxW-1:0]] <= key;
      if (cmd.store_key) v_ff <= key;
      lrd_ff <= list_mem[list_raddr];
      krd_ff <= key_mem[lrd_ff];
      if (cmd.append) list_mem[count_ff[IdxW-1:0]] <= count_ff[IdxW-1:0];
      if (cmd.shift_step) begin
         // ptr walks from the placement rank to the end, carrying one entry
         if (ptr_ff == count_ff) list_mem[ptr_ff[IdxW-1:0]] <= sh_ff;
         else begin
            list_mem[ptr_ff[IdxW-1:0]] <= (ptr_ff == pos_ff) ? count_ff[IdxW-1:0] : sh_ff;
         end
         sh_ff <= list_mem[ptr_ff[IdxW-1:0]];
      end
   end

   // pointers and counters
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      lo_in = lo_ff; hi_in = hi_ff; pos_in = pos_ff; ptr_in = ptr_ff;
      if (cmd.store_key) begin
         lo_in = '0;
         hi_in = count_ff - CntW'(1);
      end
      if (cmd.rd_first) begin
         pos_in = '0;
      end
      // unordered compares fall through to placement at mid
      if (cmd.mid_step) begin
         if (lt_v) hi_in = mid;
         else if (gt_v) lo_in = mid;
         else pos_in = mid;
      end
      if (cmd.rd_mid && (hi_ff - lo_ff + CntW'(1) <= CntW'(2))) pos_in = hi_ff;
      if (cmd.shift_step) ptr_in = ptr_ff + CntW'(1);
      if (cmd.append || (cmd.shift_step && ptr_ff == count_ff)) count_in = count_ff + CntW'(1);
      if (cmd.drop) drop_in = 1'b1;
      if (cmd.em_rd) ptr_in = '0;
      if (cmd.em_next) ptr_in = ptr_ff + CntW'(1);
      if (cmd.clear_set) begin
         count_in = '0;
         drop_in = 1'b0;
         ptr_in = '0;
      end
      if (cmd.rd_first || cmd.mid_step) ptr_in = pos_in;
      if (cmd.rd_mid && (hi_ff - lo_ff + CntW'(1) <= CntW'(2))) ptr_in = hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
         ptr_ff   <= ptr_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      pos_ff <= pos_in;
   end

   assign stat.full       = (count_ff == CntW'(MaxItems));
   assign stat.empty      = (count_ff == '0);
   assign stat.le_first   = !lt_v ? eq_v : 1'b1;
   assign stat.last_le    = le_rv;
   assign stat.span_small = (hi_ff - lo_ff + CntW'(1) <= CntW'(2));
   assign stat.mid_eq     = !lt_v && !gt_v;
   assign stat.shift_done = (ptr_ff == count_ff);
   assign stat.em_last    = (ptr_ff + CntW'(1) == count_ff);
   assign sorted_index    = lrd_ff;
   assign overflow        = drop_ff;

   `BIIS_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CntW'(MaxItems), "count past capacity")
   `BIIS_ASSERT_NXT(a_clear, clock, reset, cmd.clear_set, count_ff == '0 && !drop_ff, "set not cleared")
   `BIIS_ASSERT_IMP(a_no_store_full, clock, reset, cmd.store_key, !stat.full, "store while full")
endmodule

>>> sv/biis_control.sv
// controller state machine sequencing search, shift and emit
`timescale 1ns / 1ps
`include "binary_insertion_index_sort_assert.svh"
module biis_control import biis_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_final_item,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output logic     rsp_end_of_list
);
   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      wait_ff;   // set while a key read waits for its data
   logic      acc;

   assign req_stall = !(state_ff == ST_IDLE);
   assign acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               fin_in = req_final_item;
               if (stat.full) begin
                  cmd.drop = 1'b1;
                  state_in = req_final_item ? ST_EMRD : ST_IDLE;
               end else if (stat.empty) begin
                  cmd.append = 1'b1;
                  cmd.store_key = 1'b1;
                  state_in = req_final_item ? ST_EMRD : ST_IDLE;
               end else begin
                  cmd.store_key = 1'b1;
                  state_in = ST_FIRST;
               end
            end
         end
         // read rank 0 and wait for its key data
         ST_FIRST: begin
            cmd.rd_first = !wait_ff;
            if (wait_ff) state_in = ST_LAST;
         end
         ST_LAST: begin
            if (!wait_ff) begin
               if (stat.le_first) begin
                  cmd.rd_first = 1'b1;
                  state_in = ST_SHIFT;
               end else cmd.rd_last = 1'b1;
            end else state_in = ST_EDGE;
         end
         ST_EDGE: begin
            if (stat.last_le) begin
               cmd.append = 1'b1;
               state_in = fin_ff ? ST_EMRD : ST_IDLE;
            end else state_in = ST_MIDRD;
         end
         ST_MIDRD: begin
            cmd.rd_mid = !wait_ff;
            if (!wait_ff && stat.span_small) state_in = ST_SHIFT;
            else if (wait_ff) state_in = ST_MIDCM;
         end
         ST_MIDCM: begin
            cmd.mid_step = 1'b1;
            state_in = stat.mid_eq ? ST_SHIFT : ST_MIDRD;
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) state_in = fin_ff ? ST_EMRD : ST_IDLE;
         end
         // rewind the emit pointer and fetch rank 0
         ST_EMRD: begin
            cmd.em_rd = 1'b1;
            if (stat.empty) begin
               cmd.clear_set = 1'b1;
               state_in = ST_IDLE;
            end else state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (stat.em_last) begin
                  cmd.clear_set = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.em_next = 1'b1;
                  state_in = ST_EMWT;
               end
            end
         end
         ST_EMWT: state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
         wait_ff <= (state_in == state_ff) && !wait_ff &&
                    (state_ff == ST_FIRST || state_ff == ST_LAST || state_ff == ST_MIDRD);
      end
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_end_of_list = stat.em_last;

   `BIIS_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `BIIS_ASSERT_NXT(a_emit_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "word lost")
   `BIIS_ASSERT_IMP(a_busy, clock, reset, rsp_valid, req_stall, "input taken during emit")
endmodule

>>> sv/binary_insertion_index_sort.sv
// top level of the binary insertion index sort block
//  channel | direction | fields
//  req_    | in        | key, final_item
//  rsp_    | out       | sorted_index, end_of_list, overflow
// a key is stored and compared with rank 0 for a front insert, then with the
// last rank for an append; else halving steps compare the mid key until a span
// of two or fewer settles the rank; the list shift then moves one entry a cycle;
// emit rewinds the list pointer, then reads each word through a wait state;
// reset clears count, overflow, ptr and state; stores are undefined until written;
// req_stall is high while a key or an emit is in progress.
`timescale 1ns / 1ps
module binary_insertion_index_sort import biis_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [KeyW-1:0] req_key,
   input  logic            req_final_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [IdxW-1:0] rsp_sorted_index,
   output logic            rsp_end_of_list,
   output logic            rsp_overflow
);
   cmd_type  cmd;
   stat_type stat;

   biis_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_final_item,
      .stat, .cmd, .rsp_valid, .rsp_stall, .rsp_end_of_list
   );

   biis_datapath u_dp (
      .clock, .reset, .key(req_key), .cmd, .stat,
      .sorted_index(rsp_sorted_index), .overflow(rsp_overflow)
   );
endmodule

>>> dv/tb_binary_insertion_index_sort.sv
// testbench for the index sort block: directed and random keys against an argsort predictor
`timescale 1ns / 1ps
module tb_binary_insertion_index_sort;
   import biis_pkg::*;

   // expected output word
   typedef struct {
      logic [IdxW-1:0] sorted_index;
      logic            end_of_list;
      logic            overflow;
   } rank_word_type;

   // argsort predictor and queue of expected ranks
   class rank_board_type;
      logic [KeyW-1:0] keys [MaxItems];
      logic [IdxW-1:0] order [MaxItems];
      int              count;
      bit              dropped;
      rank_word_type   pending [$];
      int              errors;

      function automatic bit is_nan(logic [KeyW-1:0] a);
         return (a[62:52] == 11'h7ff) && (a[51:0] != '0);
      endfunction

      // ieee less-than written from the sign-magnitude view
      function automatic bit less(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
         if (is_nan(a) || is_nan(b)) return 0;
         if (a[62:0] == '0 && b[62:0] == '0) return 0;
         if (a[63] != b[63]) return a[63];
         return a[63] ? (a[62:0] > b[62:0]) : (a[62:0] < b[62:0]);
      endfunction

      function automatic bit equal(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
         if (is_nan(a) || is_nan(b)) return 0;
         return (a == b) || (a[62:0] == '0 && b[62:0] == '0);
      endfunction

      function automatic bit less_eq(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
         return less(a, b) || equal(a, b);
      endfunction

      function automatic void shift_in(int pos, int n);
         for (int j = n; j > pos; j--) order[j] = order[j-1];
         order[pos] = n[IdxW-1:0];
      endfunction

      // binary insertion of arrival index n
      function automatic void place(int n);
         logic [KeyW-1:0] v;
         logic [KeyW-1:0] m;
         int lo, hi, span, mid;
         v = keys[n];
         if (n == 0) begin
            order[0] = '0;
            return;
         end
         lo = 0;
         hi = n - 1;
         span = n;
         if (less_eq(v, keys[order[0]])) begin
            shift_in(0, n);
            return;
         end
         if (less_eq(keys[order[hi]], v)) begin
            order[n] = n[IdxW-1:0];
            return;
         end
         forever begin
            if (span <= 2) begin
               shift_in(hi, n);
               return;
            end
            mid = lo + span / 2;
            m = keys[order[mid]];
            if (less(v, m)) hi = mid;
            else if (less(m, v)) lo = mid;
            else begin
               shift_in(mid, n);
               return;
            end
            span = hi - lo + 1;
         end
      endfunction

      function automatic void note_key(logic [KeyW-1:0] k, logic fin);
         rank_word_type w;
         if (count < MaxItems) begin
            keys[count] = k;
            place(count);
            count++;
         end else dropped = 1;
         if (!fin) return;
         for (int i = 0; i < count; i++) begin
            w.sorted_index = order[i];
            w.end_of_list = (i == count - 1);
            w.overflow = dropped;
            pending.push_back(w);
         end
         count = 0;
         dropped = 0;
      endfunction

      function automatic void check_word(logic [IdxW-1:0] idx, logic eol, logic ovf);
         rank_word_type w;
         if (pending.size() == 0) begin
            $error("unexpected word: sorted_index %0d", idx);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (idx !== w.sorted_index) begin
            $error("sorted_index expected %0d actual %0d", w.sorted_index, idx);
            errors++;
         end
         if (eol !== w.end_of_list) begin
            $error("end_of_list expected %0d actual %0d", w.end_of_list, eol);
            errors++;
         end
         if (ovf !== w.overflow) begin
            $error("overflow expected %0d actual %0d", w.overflow, ovf);
            errors++;
         end
      endfunction
   endclass

   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   logic            req_stall;
   logic [KeyW-1:0] req_key = '0;
   logic            req_final_item = 0;
   logic            rsp_valid;
   logic            rsp_stall = 0;
   logic [IdxW-1:0] rsp_sorted_index;
   logic            rsp_end_of_list;
   logic            rsp_overflow;

   rank_board_type board = new();
   bit             calm = 0;
   longint         cycles = 0;
   int             sent = 0;

   binary_insertion_index_sort dut (.*);

   always #5 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("FAIL");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_sorted_index, rsp_end_of_list, rsp_overflow);
   end

   // receiver stalls in bursts
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 0;
      end
   end

   // random key with a bias toward special values and duplicates
   function automatic logic [KeyW-1:0] pick_key();
      logic [KeyW-1:0] k;
      case ($urandom_range(0, 9))
         0: k = {1'($urandom_range(0, 1)), 63'h0};
         1: k = {1'($urandom_range(0, 1)), 11'h7ff, 52'h0};
         2: k = {1'($urandom_range(0, 1)), 11'h7ff, 20'h0, 32'($urandom() | 32'h1)};
         3: k = {1'($urandom_range(0, 1)), 11'h3ff, 49'h0, 3'($urandom_range(0, 7))};
         4: k = {1'($urandom_range(0, 1)), 11'h0, 20'h0, 32'($urandom())};
         default: k = {$urandom(), $urandom()};
      endcase
      return k;
   endfunction

   // send one word, with random gaps before it
   task automatic send_key(logic [KeyW-1:0] k, logic fin);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1;
      req_key <= k;
      req_final_item <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_key(k, fin);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_set(int len);
      for (int i = 0; i < len; i++) send_key(pick_key(), i == len - 1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: single key, zeros, infinities, nan, duplicates
      send_key(64'h0, 1);
      send_key(64'h8000_0000_0000_0000, 0);
      send_key(64'h0, 0);
      send_key(64'hfff0_0000_0000_0000, 0);
      send_key(64'h7ff0_0000_0000_0000, 0);
      send_key(64'h7ff8_0000_0000_0001, 0);
      send_key(64'h3ff0_0000_0000_0000, 0);
      send_key(64'h3ff0_0000_0000_0000, 0);
      send_key(64'hffff_ffff_ffff_ffff, 1);
      // full set of 64, then overflow with final on a dropped key
      for (int i = 0; i < 66; i++) send_key(pick_key(), i == 65);
      // exactly full set ending on the last stored key
      send_set(64);

      // random sets, mostly small
      while (sent < 430) begin
         if (sent > 380) calm = 1;
         send_set($urandom_range(0, 7) == 0 ? $urandom_range(30, 66)
                                             : $urandom_range(1, 12));
      end
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

>>> files.f
+incdir+sv
sv/biis_pkg.sv
sv/biis_datapath.sv
sv/biis_control.sv
sv/binary_insertion_index_sort.sv
dv/tb_binary_insertion_index_sort.sv
